/* sv/sem_pkg.sv */
`timescale 1ns / 1ps
package sem_pkg;

    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int ROW_W       = 16;
    localparam int IROW_W      = 17;
    localparam int GRAD_W      = 11;
    localparam int SQ_W        = 21;
    localparam int ROOT_IN_W   = 16;
    localparam int REM_W       = 11;
    localparam int STEP_W      = 3;
    localparam int ROOT_STEPS  = 8;
    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam logic [FW_W-1:0]      FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FH_W-1:0]      FRAME_HEIGHT_RESET = 16'd768;
    localparam logic [SQ_W-1:0]      SAT_LIMIT          = 21'd64770;
    localparam logic [CH_W-1:0]      EDGE_MAX           = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic square;
        logic root_init;
        logic root_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic root_done;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/sem_ctrl.sv */
`timescale 1ns / 1ps
module sem_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sem_pkg::dp_status_t status,
    output sem_pkg::ctrl_cmd_t  cmd
);

    sem_pkg::ctrl_state_t state_reg;
    sem_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && !status.drop)
                begin
                    cmd.accept = 1'b1;
                    state_next = sem_pkg::ST_LOAD;
                end
            end
            sem_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.emit ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
            end
            sem_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = sem_pkg::ST_ROOT_INIT;
            end
            sem_pkg::ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = sem_pkg::ST_OUTPUT;
                end
            end
            sem_pkg::ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/sem_dp.sv */
`timescale 1ns / 1ps
module sem_dp
#(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sem_pkg::PIX_W-1:0]         s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sem_pkg::PIX_W-1:0]         m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  sem_pkg::ctrl_cmd_t                cmd,
    output sem_pkg::dp_status_t               status
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int PW = sem_pkg::PIX_W;
    localparam int CH = sem_pkg::CH_W;
    localparam int NC = sem_pkg::NUM_CH;
    localparam int GW = sem_pkg::GRAD_W;
    localparam int SW = sem_pkg::SQ_W;
    localparam int RW = sem_pkg::REM_W;

    logic [sem_pkg::FW_W-1:0]   width_reg;
    logic [sem_pkg::FH_W-1:0]   height_reg;
    logic [CW-1:0]              ic_reg;
    logic [sem_pkg::IROW_W-1:0] ir_reg;
    logic [CW-1:0]              oc_reg;
    logic [sem_pkg::ROW_W-1:0]  orow_reg;
    logic [PW-1:0]              win_reg [9];
    logic [PW-1:0]              pix_reg;
    logic [PW-1:0]              top_reg;
    logic [PW-1:0]              mid_reg;
    logic [PW-1:0]              older_mem [MAX_WIDTH];
    logic [PW-1:0]              prev_mem [MAX_WIDTH];
    logic signed [GW-1:0]       gx_reg [NC];
    logic signed [GW-1:0]       gy_reg [NC];
    logic [SW-1:0]              gx2_reg [NC];
    logic [SW-1:0]              gy2_reg [NC];
    logic [sem_pkg::ROOT_IN_W-1:0] nsh_reg [NC];
    logic [RW-1:0]              rem_reg [NC];
    logic [CH-1:0]              root_reg [NC];
    logic [NC-1:0]              sat_reg;
    logic [sem_pkg::STEP_W-1:0] step_reg;
    logic                       last_reg;
    logic                       last_q_reg;
    logic                       m_tvalid_reg;
    logic [PW-1:0]              m_tdata_reg;
    logic                       m_tlast_reg;

    logic [31:0]                wsel;
    logic [WW-1:0]              eff_w;
    logic [sem_pkg::FH_W-1:0]   eff_h;
    logic                       inframe;
    logic                       emit;
    logic                       last;
    logic [PW-1:0]              cur;
    logic [PW-1:0]              shifted [9];
    logic [PW-1:0]              ew [9];
    logic                       top_ok;
    logic                       bot_ok;
    logic                       left_ok;
    logic                       right_ok;
    logic [WW-1:0]              ic_inc;
    logic [WW-1:0]              oc_inc;
    logic signed [GW-1:0]       gx [NC];
    logic signed [GW-1:0]       gy [NC];
    logic signed [GW-1:0]       tap [9];
    logic [RW-1:0]              rem_sh [NC];
    logic [RW-1:0]              trial [NC];
    logic [SW-1:0]              nsum [NC];
    logic [PW-1:0]              result;

    always_comb
    begin
        if (width_reg == '0)
        begin
            wsel = 32'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            wsel = 32'(MAX_WIDTH);
        end
        else
        begin
            wsel = 32'(width_reg);
        end
    end

    assign eff_w   = wsel[WW-1:0];
    assign eff_h   = (height_reg == '0) ? sem_pkg::FH_W'(1) : height_reg;
    assign inframe = ir_reg < {1'b0, eff_h};
    assign emit    = (ir_reg >= sem_pkg::IROW_W'(2))
                  || ((ir_reg == sem_pkg::IROW_W'(1)) && (ic_reg != '0));
    assign last    = ({1'b0, orow_reg} == ({1'b0, eff_h} - sem_pkg::IROW_W'(1)))
                  && ({1'b0, oc_reg} == (eff_w - WW'(1)));
    assign cur     = inframe ? pix_reg : '0;
    assign ic_inc  = {1'b0, ic_reg} + WW'(1);
    assign oc_inc  = {1'b0, oc_reg} + WW'(1);

    assign top_ok   = orow_reg != '0;
    assign bot_ok   = ({1'b0, orow_reg} + sem_pkg::IROW_W'(1)) < {1'b0, eff_h};
    assign left_ok  = oc_reg != '0;
    assign right_ok = oc_inc < eff_w;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[3*r]   = win_reg[3*r+1];
            shifted[3*r+1] = win_reg[3*r+2];
        end
        shifted[2] = top_reg;
        shifted[5] = mid_reg;
        shifted[8] = cur;
        for (int k = 0; k < 9; k++)
        begin
            ew[k] = shifted[k];
        end
        if (ic_reg == '0)
        begin
            ew[2] = '0;
            ew[5] = '0;
            ew[8] = '0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if ((k < 3 && !top_ok) || (k > 5 && !bot_ok)
                    || ((k % 3) == 0 && !left_ok) || ((k % 3) == 2 && !right_ok))
                begin
                    tap[k] = '0;
                end
                else
                begin
                    tap[k] = GW'(ew[k][c*CH +: CH]);
                end
            end
            gx[c] = (tap[2] + (tap[5] <<< 1) + tap[8]) - (tap[0] + (tap[3] <<< 1) + tap[6]);
            gy[c] = (tap[6] + (tap[7] <<< 1) + tap[8]) - (tap[0] + (tap[1] <<< 1) + tap[2]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            nsum[c]   = gx2_reg[c] + gy2_reg[c];
            rem_sh[c] = {rem_reg[c][RW-3:0], nsh_reg[c][sem_pkg::ROOT_IN_W-1 -: 2]};
            trial[c]  = RW'({root_reg[c], 2'b01});
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (sat_reg[c])
            begin
                result[c*CH +: CH] = sem_pkg::EDGE_MAX;
            end
            else if (rem_reg[c] > RW'(root_reg[c]))
            begin
                result[c*CH +: CH] = root_reg[c] + CH'(1);
            end
            else
            begin
                result[c*CH +: CH] = root_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= s_tdata;
            top_reg <= older_mem[ic_reg];
            mid_reg <= prev_mem[ic_reg];
        end
        if (cmd.load && inframe && !(emit && last))
        begin
            older_mem[ic_reg] <= mid_reg;
            prev_mem[ic_reg]  <= cur;
        end
        if (cmd.load)
        begin
            for (int c = 0; c < NC; c++)
            begin
                gx_reg[c] <= gx[c];
                gy_reg[c] <= gy[c];
            end
            last_reg <= last;
        end
        if (cmd.square)
        begin
            for (int c = 0; c < NC; c++)
            begin
                gx2_reg[c] <= SW'(gx_reg[c]) * SW'(gx_reg[c]);
                gy2_reg[c] <= SW'(gy_reg[c]) * SW'(gy_reg[c]);
            end
            last_q_reg <= last_reg;
        end
        if (cmd.root_init)
        begin
            for (int c = 0; c < NC; c++)
            begin
                sat_reg[c]  <= nsum[c] > sem_pkg::SAT_LIMIT;
                nsh_reg[c]  <= nsum[c][sem_pkg::ROOT_IN_W-1:0];
                rem_reg[c]  <= '0;
                root_reg[c] <= '0;
            end
            step_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            for (int c = 0; c < NC; c++)
            begin
                nsh_reg[c] <= nsh_reg[c] << 2;
                if (rem_sh[c] >= trial[c])
                begin
                    rem_reg[c]  <= rem_sh[c] - trial[c];
                    root_reg[c] <= {root_reg[c][CH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c]  <= rem_sh[c];
                    root_reg[c] <= {root_reg[c][CH-2:0], 1'b0};
                end
            end
            step_reg <= step_reg + sem_pkg::STEP_W'(1);
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= result;
            m_tlast_reg <= last_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= sem_pkg::FRAME_WIDTH_RESET;
            height_reg   <= sem_pkg::FRAME_HEIGHT_RESET;
            ic_reg       <= '0;
            ir_reg       <= '0;
            oc_reg       <= '0;
            orow_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we && (cfg_index == sem_pkg::CFG_FRAME_WIDTH
                           || cfg_index == sem_pkg::CFG_FRAME_HEIGHT))
            begin
                if (cfg_index == sem_pkg::CFG_FRAME_WIDTH)
                begin
                    width_reg <= cfg_data[sem_pkg::FW_W-1:0];
                end
                else
                begin
                    height_reg <= cfg_data[sem_pkg::FH_W-1:0];
                end
                ic_reg   <= '0;
                ir_reg   <= '0;
                oc_reg   <= '0;
                orow_reg <= '0;
                for (int k = 0; k < 9; k++)
                begin
                    win_reg[k] <= '0;
                end
            end
            else if (cmd.load)
            begin
                if (emit && last)
                begin
                    ic_reg   <= '0;
                    ir_reg   <= '0;
                    oc_reg   <= '0;
                    orow_reg <= '0;
                    for (int k = 0; k < 9; k++)
                    begin
                        win_reg[k] <= '0;
                    end
                end
                else
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        win_reg[k] <= shifted[k];
                    end
                    if (emit)
                    begin
                        if (oc_inc >= eff_w)
                        begin
                            oc_reg   <= '0;
                            orow_reg <= orow_reg + sem_pkg::ROW_W'(1);
                        end
                        else
                        begin
                            oc_reg <= oc_inc[CW-1:0];
                        end
                    end
                    if (ic_inc >= eff_w)
                    begin
                        ic_reg <= '0;
                        ir_reg <= ir_reg + sem_pkg::IROW_W'(1);
                    end
                    else
                    begin
                        ic_reg <= ic_inc[CW-1:0];
                    end
                end
            end
        end
    end

    assign status.drop      = s_tuser && inframe;
    assign status.emit      = emit;
    assign status.root_done = step_reg == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* sv/sobel_edge_magnitude_rgb.sv */
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, with taps outside the
// frame taken as zero. Each result is round(sqrt(Gx^2 + Gy^2)) per color, saturated at
// 255, and leaves one row and one pixel behind the input; after a frame the host sends
// width + 1 flush transfers to drain it. A flush inside the frame is taken and dropped.
// An item that yields no result only updates the window and row stores; one that yields a
// result then passes the squaring stage, the 8 steps of the bit-serial square root unit
// and a wait for a free output register, with no new item taken meanwhile. Row stores are
// single-port memories read on the accept cycle. Configuration writes restart the frame.
module sobel_edge_magnitude_rgb
#(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [sem_pkg::PIX_W-1:0]      s_tdata,
    // action [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red_edge [7:0], green_edge [15:8], blue_edge [23:16]
    output logic [sem_pkg::PIX_W-1:0]      m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    sem_pkg::ctrl_cmd_t  cmd;
    sem_pkg::dp_status_t status;

    sem_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sem_dp
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load, cmd.square, cmd.root_init, cmd.root_step, cmd.out_load}))
        else $error("controller issued more than one command");

    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_load_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before transfer");
`endif

endmodule
